@@ hdl/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants of the deadline countdown table
// Holds the table size, operation and status codes, the sequencer states
// and the structs passed between the controller, slot store and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dct_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIVE_W  = $clog2(ENTRIES + 1);

    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        F_REGISTER   = 3'd0,
        F_UNREGISTER = 3'd1,
        F_SET_SLICE  = 3'd2,
        F_READ_REM   = 3'd3,
        F_TRIGGER    = 3'd4,
        F_STOP       = 3'd5,
        F_CLEAR_STOP = 3'd6,
        F_COUNT      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_CB_REJECT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FIND  = 2'd1,
        S_APPLY = 2'd2,
        S_MIN   = 2'd3
    } state_t;

    // Write request into the slot store; tag covers id and flags.
    typedef struct packed {
        logic             en_slice;
        logic             en_rem;
        logic             en_tag;
        logic [IDX_W-1:0] idx;
        logic [30:0]      slice;
        logic [30:0]      rem;
        logic [31:0]      id;
        logic [7:0]       flags;
    } slot_wr_t;

    typedef struct packed {
        logic [30:0] slice;
        logic [30:0] rem;
        logic [31:0] id;
    } slot_rd_t;

    typedef struct packed {
        logic        eq;
        logic        lt;
    } cmp_t;

    typedef struct packed {
        logic              fin;
        status_t           status;
        logic [31:0]       new_id;
        logic [31:0]       remaining;
        logic [LIVE_W-1:0] live;
        logic [30:0]       countdown;
        logic              stop;
    } result_t;

    // Periods below 1 become 1.
    function automatic logic [30:0] clamp_slice(input logic [31:0] raw);
        logic [30:0] s;
        s = raw[30:0];
        if (raw[31] || (raw == 32'd0)) begin
            s = 31'd1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/dct_cmp.sv @@
// ----------------------------------------------------------------------------
// dct_cmp: shared compare unit
// One 33-bit subtractor that gives equality (id match) and unsigned
// less-than (minimum search) for whichever operands the sequencer selects.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_cmp
    import dct_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output cmp_t        res
);

    logic [32:0] diff;

    assign diff   = {1'b0, a} - {1'b0, b};
    assign res.lt = diff[32];
    assign res.eq = (diff[31:0] == 32'd0);

endmodule

`default_nettype wire

@@ hdl/dct_store.sv @@
// ----------------------------------------------------------------------------
// dct_store: slot table
// Per-slot slice, remaining count, id and flags; one write port and one
// read port addressed by the sequencer's scan index.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_store
    import dct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slot_wr_t         wr,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_rd_t         rd
);

    logic [30:0] slice_reg [ENTRIES];
    logic [30:0] rem_reg   [ENTRIES];
    logic [31:0] id_reg    [ENTRIES];
    logic [7:0]  flags_reg [ENTRIES];

    // Zero slice marks a free slot, so it clears on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slice_reg[i] <= '0;
            end
        end
        else if (wr.en_slice)
        begin
            slice_reg[wr.idx] <= wr.slice;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en_rem)
        begin
            rem_reg[wr.idx] <= wr.rem;
        end
        if (wr.en_tag)
        begin
            id_reg[wr.idx]    <= wr.id;
            flags_reg[wr.idx] <= wr.flags;
        end
    end

    assign rd.slice = slice_reg[rd_idx];
    assign rd.rem   = rem_reg[rd_idx];
    assign rd.id    = id_reg[rd_idx];

endmodule

`default_nettype wire

@@ hdl/dct_ctrl.sv @@
// ----------------------------------------------------------------------------
// dct_ctrl: operation sequencer
// Latches a command, scans the slots for a free or matching entry, applies
// the change and re-arms the countdown through a minimum scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_ctrl
    import dct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       func,
    input  logic [31:0]      entry_id,
    input  logic [31:0]      slice,
    input  logic [7:0]       entry_flags,
    input  logic             callback_ok,
    input  logic             oom_req,
    output logic             busy,
    output slot_wr_t         wr,
    output logic [IDX_W-1:0] rd_idx,
    input  slot_rd_t         rd,
    output logic [31:0]      cmp_a,
    output logic [31:0]      cmp_b,
    input  cmp_t             cmp,
    output result_t          res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t            state_reg,     state_next;
    logic [IDX_W-1:0]  idx_reg,       idx_next;
    func_t             func_reg,      func_next;
    logic [31:0]       id_reg,        id_next;
    logic [30:0]       slice_reg,     slice_next;
    logic [7:0]        flags_reg,     flags_next;
    logic              oom_reg,       oom_next;
    logic [30:0]       best_reg,      best_next;
    logic [31:0]       idc_reg,       idc_next;
    logic [LIVE_W-1:0] live_reg,      live_next;
    logic [30:0]       countdown_reg, countdown_next;
    logic              stop_reg,      stop_next;

    logic [31:0] idc_inc;
    logic        hit;
    logic [30:0] cand;
    logic        rearm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idc_reg       <= '0;
            live_reg      <= '0;
            countdown_reg <= '0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idc_reg       <= idc_next;
            live_reg      <= live_next;
            countdown_reg <= countdown_next;
            stop_reg      <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        func_reg  <= func_next;
        id_reg    <= id_next;
        slice_reg <= slice_next;
        flags_reg <= flags_next;
        oom_reg   <= oom_next;
        best_reg  <= best_next;
    end

    // Id counter wraps and skips zero.
    assign idc_inc = (idc_reg == 32'hFFFF_FFFF) ? 32'd1 : idc_reg + 32'd1;

    assign busy   = (state_reg != S_IDLE);
    assign rd_idx = idx_reg;

    always_comb
    begin
        if (state_reg == S_MIN)
        begin
            cmp_a = {1'b0, rd.rem};
            cmp_b = {1'b0, best_reg};
        end
        else
        begin
            cmp_a = rd.id;
            cmp_b = id_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        slice_next     = slice_reg;
        flags_next     = flags_reg;
        oom_next       = oom_reg;
        best_next      = best_reg;
        idc_next       = idc_reg;
        live_next      = live_reg;
        countdown_next = countdown_reg;
        stop_next      = stop_reg;

        wr          = '0;
        wr.idx      = idx_reg;
        wr.flags    = flags_reg;
        wr.id       = idc_inc;

        res           = '0;
        res.status    = ST_OK;
        hit           = 1'b0;
        cand          = best_reg;
        rearm         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func_t'(func);
                    id_next    = entry_id;
                    slice_next = clamp_slice(slice);
                    flags_next = entry_flags;
                    oom_next   = oom_req;
                    idx_next   = '0;
                    case (func_t'(func))
                        F_REGISTER:
                        begin
                            if (!callback_ok)
                            begin
                                res.fin    = 1'b1;
                                res.status = ST_CB_REJECT;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        F_UNREGISTER, F_SET_SLICE, F_READ_REM, F_TRIGGER:
                        begin
                            state_next = S_FIND;
                        end
                        F_STOP:
                        begin
                            stop_next      = 1'b1;
                            countdown_next = '0;
                            res.fin        = 1'b1;
                        end
                        F_CLEAR_STOP:
                        begin
                            stop_next = 1'b0;
                            if (oom_req)
                            begin
                                countdown_next = '0;
                                res.fin        = 1'b1;
                            end
                            else
                            begin
                                best_next  = COUNT_MAX;
                                state_next = S_MIN;
                            end
                        end
                        default:
                        begin
                            res.fin = 1'b1;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                if (func_reg == F_REGISTER)
                begin
                    hit = (rd.slice == '0);
                end
                else
                begin
                    hit = (rd.slice != '0) && cmp.eq && (id_reg != 32'd0);
                end

                if (hit)
                begin
                    state_next = S_APPLY;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res.fin    = 1'b1;
                    state_next = S_IDLE;
                    if (func_reg == F_REGISTER)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        res.status = ST_NOT_FOUND;
                    end
                    if (func_reg == F_READ_REM)
                    begin
                        res.remaining = 32'hFFFF_FFFF;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_APPLY:
            begin
                case (func_reg)
                    F_REGISTER:
                    begin
                        wr.en_slice = 1'b1;
                        wr.en_rem   = 1'b1;
                        wr.en_tag   = 1'b1;
                        wr.slice    = slice_reg;
                        wr.rem      = slice_reg;
                        idc_next    = idc_inc;
                        live_next   = live_reg + LIVE_W'(1);
                        rearm       = 1'b1;
                    end
                    F_UNREGISTER:
                    begin
                        wr.en_slice = 1'b1;
                        wr.slice    = '0;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - LIVE_W'(1);
                        end
                        rearm = 1'b1;
                    end
                    F_SET_SLICE:
                    begin
                        wr.en_slice = 1'b1;
                        wr.en_rem   = 1'b1;
                        wr.slice    = slice_reg;
                        wr.rem      = slice_reg;
                        rearm       = 1'b1;
                    end
                    F_READ_REM:
                    begin
                        res.remaining = {1'b0, rd.rem};
                        res.fin       = 1'b1;
                        state_next    = S_IDLE;
                    end
                    F_TRIGGER:
                    begin
                        wr.en_rem      = 1'b1;
                        wr.rem         = '0;
                        countdown_next = '0;
                        res.fin        = 1'b1;
                        state_next     = S_IDLE;
                    end
                    default:
                    begin
                        res.fin    = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase

                if (rearm)
                begin
                    if (stop_reg || oom_reg)
                    begin
                        countdown_next = '0;
                        res.fin        = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        best_next  = COUNT_MAX;
                        idx_next   = '0;
                        state_next = S_MIN;
                    end
                end
            end

            S_MIN:
            begin
                if ((rd.slice != '0) && cmp.lt)
                begin
                    cand = rd.rem;
                end
                best_next = cand;
                if (idx_reg == LAST_IDX)
                begin
                    countdown_next = (cand == '0) ? 31'd1 : cand;
                    res.fin        = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res.fin && (res.status == ST_OK) && (state_reg != S_IDLE)
            && (func_reg == F_REGISTER))
        begin
            res.new_id = idc_next;
        end
        res.live      = live_next;
        res.countdown = countdown_next;
        res.stop      = stop_next;
    end

endmodule

`default_nettype wire

@@ hdl/deadline_countdown_table.sv @@
// ----------------------------------------------------------------------------
// deadline_countdown_table: table of periodic deadline entries
// Top level: command port, slot store, shared compare unit, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command on func and its operand ports and raise start; the
//   command is taken at a clock edge where start is high and busy is low.
//   Each command yields one result beat: done is high for exactly one cycle
//   with status, new_id, remaining_out, live_entries, countdown_out and
//   stop_out valid in that cycle. The receiver cannot stall the beat.
//   Stop, clear stop with a pending out-of-memory, count and a rejected
//   register answer in the cycle after acceptance and leave busy low.
//   Lookup commands scan the slots one per cycle, then take an apply
//   step; a change that re-arms the countdown adds a minimum scan over
//   all slots unless a stop or out-of-memory is pending. Both scans share
//   the single compare unit, one use per cycle.
//   Reset clears every slot to free, the id counter, the live count, the
//   countdown and the stop flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_countdown_table
    import dct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [31:0]        entry_id,
    input  logic signed [31:0] slice,
    input  logic [7:0]         entry_flags,
    input  logic               callback_ok,
    input  logic               oom_req,
    output logic               done,
    output logic [1:0]         status,
    output logic [31:0]        new_id,
    output logic signed [31:0] remaining_out,
    output logic [3:0]         live_entries,
    output logic [30:0]        countdown_out,
    output logic               stop_out
);

    slot_wr_t         wr;
    slot_rd_t         rd;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      cmp_a;
    logic [31:0]      cmp_b;
    cmp_t             cmp;
    result_t          res;

    logic               done_reg;
    logic [1:0]         status_reg;
    logic [31:0]        new_id_reg;
    logic [31:0]        remaining_reg;
    logic [3:0]         live_reg;
    logic [30:0]        countdown_reg;
    logic               stop_reg;

    dct_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .entry_id    (entry_id),
        .slice       (slice),
        .entry_flags (entry_flags),
        .callback_ok (callback_ok),
        .oom_req     (oom_req),
        .busy        (busy),
        .wr          (wr),
        .rd_idx      (rd_idx),
        .rd          (rd),
        .cmp_a       (cmp_a),
        .cmp_b       (cmp_b),
        .cmp         (cmp),
        .res         (res)
    );

    dct_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd     (rd)
    );

    dct_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    // Strobe the result beat for one cycle after the sequencer finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.fin;
        end
    end

    // Hold the payload of the last beat; load only on a finished command.
    always_ff @(posedge clk)
    begin
        if (res.fin)
        begin
            status_reg    <= res.status;
            new_id_reg    <= res.new_id;
            remaining_reg <= res.remaining;
            live_reg      <= 4'(res.live);
            countdown_reg <= res.countdown;
            stop_reg      <= res.stop;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign new_id        = new_id_reg;
    assign remaining_out = remaining_reg;
    assign live_entries  = live_reg;
    assign countdown_out = countdown_reg;
    assign stop_out      = stop_reg;

endmodule

`default_nettype wire

@@ hdl/dct_chk.sv @@
// ----------------------------------------------------------------------------
// dct_chk: port-level checker for the deadline countdown table
// Watches command acceptance and result beats on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_chk
    import dct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic [31:0]        new_id,
    input  logic signed [31:0] remaining_out,
    input  logic [30:0]        countdown_out,
    input  logic               stop_out
);

    // An accepted command either keeps the block busy or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither busy nor answered");

    // A failed command hands out no id.
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (new_id == 32'd0))
        else $error("id handed out on a failed command");

    // While a stop is pending the countdown stays disarmed.
    a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stop_out) |-> (countdown_out == 31'd0))
        else $error("countdown armed while stop pending");

    // A remaining count of -1 only reports a missing entry.
    a_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (remaining_out == -32'sd1)) |-> (status == ST_NOT_FOUND))
        else $error("remaining -1 without not-found status");

endmodule

bind deadline_countdown_table dct_chk u_dct_chk (.*);

`default_nettype wire
